FILE: hdl/bvm_pkg.sv
// Package: constants, state encoding and helpers of the bytecode VM instruction core.
`default_nettype none
package bvm_pkg;

	localparam int MEM_BYTES   = 4096;
	localparam int STACK_DEPTH = 16;
	localparam int FONT_BASE   = 80;
	localparam int SCREEN_W    = 64;
	localparam int SCREEN_H    = 32;

	localparam int MEM_AW = $clog2(MEM_BYTES);
	localparam int SP_W   = $clog2(STACK_DEPTH);
	localparam int ROW_W  = $clog2(SCREEN_H);
	localparam int COL_W  = $clog2(SCREEN_W);

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_EXEC = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	localparam logic [3:0] OP_SYS  = 4'h0;
	localparam logic [3:0] OP_JP   = 4'h1;
	localparam logic [3:0] OP_CALL = 4'h2;
	localparam logic [3:0] OP_SEB  = 4'h3;
	localparam logic [3:0] OP_SNEB = 4'h4;
	localparam logic [3:0] OP_SER  = 4'h5;
	localparam logic [3:0] OP_LDB  = 4'h6;
	localparam logic [3:0] OP_ADDB = 4'h7;
	localparam logic [3:0] OP_ALU  = 4'h8;
	localparam logic [3:0] OP_SNER = 4'h9;
	localparam logic [3:0] OP_LDI  = 4'hA;
	localparam logic [3:0] OP_JPV0 = 4'hB;
	localparam logic [3:0] OP_RND  = 4'hC;
	localparam logic [3:0] OP_DRW  = 4'hD;
	localparam logic [3:0] OP_KEY  = 4'hE;
	localparam logic [3:0] OP_MISC = 4'hF;

	localparam logic [3:0] ALU_MOV = 4'h0;
	localparam logic [3:0] ALU_OR  = 4'h1;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4;
	localparam logic [3:0] ALU_SUB = 4'h5;
	localparam logic [3:0] ALU_SHR = 4'h6;
	localparam logic [3:0] ALU_SBN = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'hE;

	localparam logic [15:0] W_CLS = 16'h00E0;
	localparam logic [15:0] W_RET = 16'h00EE;

	localparam logic [7:0] K_SKP  = 8'h9E;
	localparam logic [7:0] K_SKNP = 8'hA1;
	localparam logic [7:0] F_GDT  = 8'h07;
	localparam logic [7:0] F_WK   = 8'h0A;
	localparam logic [7:0] F_SDT  = 8'h15;
	localparam logic [7:0] F_SST  = 8'h18;
	localparam logic [7:0] F_ADI  = 8'h1E;
	localparam logic [7:0] F_FNT  = 8'h29;
	localparam logic [7:0] F_BCD  = 8'h33;
	localparam logic [7:0] F_SAV  = 8'h55;
	localparam logic [7:0] F_LOD  = 8'h65;

	localparam logic [3:0] REG_VF = 4'hF;

	typedef enum logic [4:0] {
		S_IDLE, S_FH, S_FL, S_RX, S_RY, S_EX, S_WB,
		S_DRD, S_DWR, S_DVF, S_BCD, S_SVRD, S_SVWR, S_LDRD, S_LDWR,
		S_SRD, S_FIN, S_RESP
	} state_t;

	typedef struct packed {
		logic [7:0] hund;
		logic [7:0] tens;
		logic [7:0] ones;
	} bcd_t;

	// Decimal split by compare and reciprocal multiply.
	function automatic bcd_t bcd_split(input logic [7:0] v);
		bcd_t r;
		logic [7:0] rem;
		logic [15:0] prod;
		r.hund = (v >= 8'd200) ? 8'd2 : ((v >= 8'd100) ? 8'd1 : 8'd0);
		rem = v - 8'(r.hund * 8'd100);
		prod = 16'(rem) * 16'd205;
		r.tens = 8'(prod >> 11);
		r.ones = rem - 8'(r.tens * 8'd10);
		return r;
	endfunction

	function automatic logic [3:0] top_key(input logic [15:0] k);
		logic [3:0] r;
		r = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (k[i]) r = 4'(i);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/bvm_ram.sv
// Generic RAM: one write port, one read port with registered read data.
`default_nettype none
module bvm_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: hdl/bytecode_vm_instruction_core.sv
// Top level: CHIP-8 style instruction core with memory-centered sequencer.
// Usage:
//   A transaction is taken when start is high and busy is low; kind, address,
//   load_byte, keys_down and random_byte are sampled then. Exactly one result
//   follows: done is high for one cycle with program_counter, executed_opcode,
//   flag_value, beep, unknown_opcode and screen_row valid in that cycle.
//   The receiver cannot stall; results are registered and held only for that cycle.
// Sequence (start to done):
//   load byte: memory is written as it is taken; screen read: a row above 31
//   skips the screen RAM and reads zero. execute: fetch two bytes, read
//   registers, execute; two-register flag ops add a write-back step, draw a
//   read step and a write step per sprite row (ending at the screen bottom),
//   BCD writes three digits, register save and load one read and one write per
//   register 0..x. One item is in flight at a time; busy stays high until done.
// Memory, registers and screen sit in synchronous RAMs with registered reads.
// Register file and screen rows carry valid bits cleared at reset, so they read
// zero until written; a clear-screen clears all screen valid bits at once.
// Reset: pc 0x200, index, stack pointer and timers zero. Main memory and the
// return stack are undefined until written.
`default_nettype none
module bytecode_vm_instruction_core
	import bvm_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [1:0]  kind,
	input  wire  [11:0] address,
	input  wire  [7:0]  load_byte,
	input  wire  [15:0] keys_down,
	input  wire  [7:0]  random_byte,
	output logic        busy,
	output logic        done,
	output logic [11:0] program_counter,
	output logic [15:0] executed_opcode,
	output logic [7:0]  flag_value,
	output logic        beep,
	output logic        unknown_opcode,
	output logic [63:0] screen_row
);
	state_t state_q, state_d;

	// control and architectural registers
	logic [MEM_AW-1:0] pc_q;
	logic [15:0]       idx_q;
	logic [SP_W-1:0]   sp_q;
	logic [7:0]        dly_q, snd_q, vf_q;
	logic [MEM_AW-1:0] stk_q [STACK_DEPTH];
	logic [15:0]       rf_vld_q;
	logic [SCREEN_H-1:0] scr_vld_q;

	// transaction payload registers
	logic [1:0]  kind_q;
	logic [11:0] addr_q;
	logic [15:0] keys_q;
	logic [7:0]  rnd_q, hi_q, vx_q, alu_q;
	logic [15:0] op_q;
	logic [3:0]  cnt_q;
	logic [COL_W-1:0] xs_q;
	logic [ROW_W-1:0] ys_q;
	logic        coll_q, beep_q, unk_q;
	logic [63:0] row_q;
	bcd_t        bcd_q;

	// RAM ports
	logic              mem_we;
	logic [MEM_AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]        mem_wdata, mem_rdata;
	logic              rf_we;
	logic [3:0]        rf_waddr, rf_raddr;
	logic [7:0]        rf_wdata, rf_rdata;
	logic              rf_rv_q;
	logic              scr_we;
	logic [ROW_W-1:0]  scr_waddr, scr_raddr;
	logic [63:0]       scr_wdata, scr_rdata;
	logic              scr_rv_q;

	bvm_ram #(.DEPTH(MEM_BYTES), .WIDTH(8)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);
	bvm_ram #(.DEPTH(16), .WIDTH(8)) u_rf (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.raddr(rf_raddr), .rdata(rf_rdata)
	);
	bvm_ram #(.DEPTH(SCREEN_H), .WIDTH(SCREEN_W)) u_scr (
		.clk(clk), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
		.raddr(scr_raddr), .rdata(scr_rdata)
	);

	logic [7:0]  rf_out, vy;
	logic [63:0] scr_out, pattern;
	logic [3:0]  op_x, op_y, op_n;
	logic [7:0]  op_kk;
	logic [MEM_AW-1:0] op_nnn, pc_p2, pc_p4, idx_a, sp_dec_ret, pc_ex;
	logic [SP_W-1:0]   sp_inc, sp_dec;
	logic [7:0]  alu_res, alu_flag;
	logic        key_dn, draw_more;
	logic [5:0]  next_row;
	logic [4:0]  next_r;
	bcd_t        bcd_now;

	assign rf_out  = rf_rv_q ? rf_rdata : 8'd0;
	assign scr_out = scr_rv_q ? scr_rdata : 64'd0;
	assign vy      = rf_out;
	assign op_x    = op_q[11:8];
	assign op_y    = op_q[7:4];
	assign op_n    = op_q[3:0];
	assign op_kk   = op_q[7:0];
	assign op_nnn  = op_q[11:0];
	assign pc_p2   = pc_q + MEM_AW'(2);
	assign pc_p4   = pc_q + MEM_AW'(4);
	assign idx_a   = idx_q[MEM_AW-1:0] + MEM_AW'(cnt_q);
	assign sp_inc  = (sp_q == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_q + SP_W'(1);
	assign sp_dec  = (sp_q == '0) ? SP_W'(STACK_DEPTH - 1) : sp_q - SP_W'(1);
	assign sp_dec_ret = stk_q[sp_dec];
	assign key_dn  = (vx_q[7:4] == 4'd0) && keys_q[vx_q[3:0]];
	assign pattern = {mem_rdata, 56'd0} >> xs_q;
	assign next_r  = 5'(cnt_q) + 5'd1;
	assign next_row = 6'(ys_q) + 6'(cnt_q) + 6'd1;
	assign draw_more = (next_r < 5'(op_n)) && (next_row < 6'(SCREEN_H));
	assign bcd_now = bcd_split(vx_q);

	always_comb begin
		alu_res  = vx_q;
		alu_flag = vf_q;
		case (op_n)
			ALU_MOV: alu_res = vy;
			ALU_OR:  alu_res = vx_q | vy;
			ALU_AND: alu_res = vx_q & vy;
			ALU_XOR: alu_res = vx_q ^ vy;
			ALU_ADD: begin
				alu_res  = vx_q + vy;
				alu_flag = {7'd0, (9'(vx_q) + 9'(vy)) > 9'd255};
			end
			ALU_SUB: begin
				alu_res  = vx_q - vy;
				alu_flag = {7'd0, vx_q > vy};
			end
			ALU_SHR: begin
				alu_res  = {1'b0, vx_q[7:1]};
				alu_flag = {7'd0, vx_q[0]};
			end
			ALU_SBN: begin
				alu_res  = vy - vx_q;
				alu_flag = {7'd0, vy > vx_q};
			end
			ALU_SHL: begin
				alu_res  = {vx_q[6:0], 1'b0};
				alu_flag = {7'd0, vx_q[7]};
			end
			default: ;
		endcase
	end

	// pc after the execute step
	always_comb begin
		pc_ex = pc_p2;
		case (op_q[15:12])
			OP_SYS:   if (op_q == W_RET) pc_ex = sp_dec_ret + MEM_AW'(2);
			OP_JP, OP_CALL: pc_ex = op_nnn;
			OP_SEB:   if (vx_q == op_kk) pc_ex = pc_p4;
			OP_SNEB:  if (vx_q != op_kk) pc_ex = pc_p4;
			OP_SER:   if (op_n == 4'd0 && vx_q == vy) pc_ex = pc_p4;
			OP_SNER:  if (op_n == 4'd0 && vx_q != vy) pc_ex = pc_p4;
			OP_JPV0:  pc_ex = MEM_AW'(vx_q) + op_nnn;
			OP_KEY: begin
				if ((op_kk == K_SKP && key_dn) || (op_kk == K_SKNP && !key_dn))
					pc_ex = pc_p4;
			end
			OP_MISC:  if (op_kk == F_WK && keys_q == 16'd0) pc_ex = pc_q;
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (kind)
						KIND_EXEC: state_d = S_FH;
						KIND_READ: state_d = (address < 12'(SCREEN_H)) ? S_SRD : S_RESP;
						default:   state_d = S_RESP;
					endcase
				end
			end
			S_FH: state_d = S_FL;
			S_FL: state_d = S_RX;
			S_RX: state_d = S_RY;
			S_RY: state_d = S_EX;
			S_EX: begin
				state_d = S_FIN;
				case (op_q[15:12])
					OP_ALU: begin
						if (op_n == ALU_ADD || op_n == ALU_SUB || op_n == ALU_SHR ||
						    op_n == ALU_SBN || op_n == ALU_SHL) state_d = S_WB;
					end
					OP_DRW: if (op_n != 4'd0) state_d = S_DRD;
					OP_MISC: begin
						if (op_kk == F_BCD) state_d = S_BCD;
						else if (op_kk == F_SAV) state_d = S_SVRD;
						else if (op_kk == F_LOD) state_d = S_LDRD;
					end
					default: ;
				endcase
			end
			S_WB:   state_d = S_FIN;
			S_DRD:  state_d = S_DWR;
			S_DWR:  state_d = draw_more ? S_DRD : S_DVF;
			S_DVF:  state_d = S_FIN;
			S_BCD:  state_d = (cnt_q == 4'd2) ? S_FIN : S_BCD;
			S_SVRD: state_d = S_SVWR;
			S_SVWR: state_d = (cnt_q == op_x) ? S_FIN : S_SVRD;
			S_LDRD: state_d = S_LDWR;
			S_LDWR: state_d = (cnt_q == op_x) ? S_FIN : S_LDRD;
			S_SRD:  state_d = S_RESP;
			S_FIN:  state_d = S_RESP;
			S_RESP: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// RAM port control
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = idx_a;
		mem_wdata = rf_out;
		mem_raddr = pc_q;
		rf_we = 1'b0;
		rf_waddr = op_x;
		rf_wdata = alu_res;
		rf_raddr = op_y;
		scr_we = 1'b0;
		scr_waddr = ys_q + ROW_W'(cnt_q);
		scr_wdata = scr_out ^ pattern;
		scr_raddr = addr_q[ROW_W-1:0];
		case (state_q)
			S_IDLE: begin
				mem_we = start && (kind == KIND_LOAD);
				mem_waddr = address;
				mem_wdata = load_byte;
				scr_raddr = address[ROW_W-1:0];
			end
			S_FH: mem_raddr = pc_p2 - MEM_AW'(1);
			S_RX: rf_raddr = (hi_q[7:4] == OP_JPV0) ? 4'd0 : hi_q[3:0];
			S_RY: rf_raddr = op_y;
			S_EX: begin
				case (op_q[15:12])
					OP_LDB: begin rf_we = 1'b1; rf_wdata = op_kk; end
					OP_ADDB: begin rf_we = 1'b1; rf_wdata = vx_q + op_kk; end
					OP_RND: begin rf_we = 1'b1; rf_wdata = rnd_q & op_kk; end
					OP_ALU: begin
						if (op_n == ALU_MOV || op_n == ALU_OR || op_n == ALU_AND ||
						    op_n == ALU_XOR) begin
							rf_we = 1'b1;
						end else if (op_n == ALU_ADD || op_n == ALU_SUB ||
						             op_n == ALU_SHR || op_n == ALU_SBN ||
						             op_n == ALU_SHL) begin
							rf_we = 1'b1;
							rf_waddr = REG_VF;
							rf_wdata = alu_flag;
						end
					end
					OP_DRW: begin
						rf_we = 1'b1;
						rf_waddr = REG_VF;
						rf_wdata = 8'd0;
						mem_raddr = idx_q[MEM_AW-1:0];
						scr_raddr = vy[ROW_W-1:0];
					end
					OP_MISC: begin
						if (op_kk == F_GDT) begin
							rf_we = 1'b1;
							rf_wdata = dly_q;
						end else if (op_kk == F_WK) begin
							rf_we = (keys_q != 16'd0);
							rf_wdata = {4'd0, top_key(keys_q)};
						end else if (op_kk == F_BCD) begin
							mem_we = 1'b1;
							mem_waddr = idx_q[MEM_AW-1:0];
							mem_wdata = bcd_now.hund;
						end
					end
					default: ;
				endcase
			end
			S_WB: begin
				rf_we = 1'b1;
				rf_wdata = alu_q;
			end
			S_DRD: begin
				mem_raddr = idx_a;
				scr_raddr = ys_q + ROW_W'(cnt_q);
			end
			S_DWR: begin
				scr_we = 1'b1;
			end
			S_DVF: begin
				rf_we = 1'b1;
				rf_waddr = REG_VF;
				rf_wdata = {7'd0, coll_q};
			end
			S_BCD: begin
				mem_we = 1'b1;
				mem_wdata = (cnt_q == 4'd1) ? bcd_q.tens : bcd_q.ones;
			end
			S_SVRD: rf_raddr = cnt_q;
			S_SVWR: mem_we = 1'b1;
			S_LDRD: mem_raddr = idx_a;
			S_LDWR: begin
				rf_we = 1'b1;
				rf_waddr = cnt_q;
				rf_wdata = mem_rdata;
			end
			default: ;
		endcase
	end

	// draw starts at row zero; the first row was issued from S_EX,
	// so S_DRD re-issues the same address harmlessly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pc_q      <= MEM_AW'(12'h200);
			idx_q     <= 16'd0;
			sp_q      <= '0;
			dly_q     <= 8'd0;
			snd_q     <= 8'd0;
			vf_q      <= 8'd0;
			rf_vld_q  <= 16'd0;
			scr_vld_q <= '0;
		end else begin
			state_q <= state_d;
			if (rf_we) begin
				rf_vld_q[rf_waddr] <= 1'b1;
				if (rf_waddr == REG_VF) vf_q <= rf_wdata;
			end
			if (scr_we) scr_vld_q[scr_waddr] <= 1'b1;
			case (state_q)
				S_EX: begin
					pc_q <= pc_ex;
					case (op_q[15:12])
						OP_SYS: begin
							if (op_q == W_CLS) scr_vld_q <= '0;
							else if (op_q == W_RET) sp_q <= sp_dec;
						end
						OP_CALL: sp_q <= sp_inc;
						OP_LDI:  idx_q <= 16'(op_nnn);
						OP_MISC: begin
							if (op_kk == F_SDT) dly_q <= vx_q;
							if (op_kk == F_SST) snd_q <= vx_q;
							if (op_kk == F_ADI) idx_q <= idx_q + 16'(vx_q);
							if (op_kk == F_FNT)
								idx_q <= 16'(FONT_BASE) + 16'(5 * vx_q[3:0]);
						end
						default: ;
					endcase
				end
				S_FIN: begin
					if (dly_q != 8'd0) dly_q <= dly_q - 8'd1;
					if (snd_q != 8'd0) snd_q <= snd_q - 8'd1;
				end
				default: ;
			endcase
		end
	end

	// payload and sequencing registers
	always_ff @(posedge clk) begin
		rf_rv_q  <= rf_vld_q[rf_raddr];
		scr_rv_q <= scr_vld_q[scr_raddr];
		if (state_q == S_EX && op_q[15:12] == OP_CALL) stk_q[sp_q] <= pc_q;
		case (state_q)
			S_IDLE: begin
				kind_q <= kind;
				addr_q <= address;
				keys_q <= keys_down;
				rnd_q  <= random_byte;
				beep_q <= 1'b0;
				unk_q  <= 1'b0;
				row_q  <= 64'd0;
				op_q   <= 16'd0;
			end
			// read data arrives in the cycle after its address
			S_FH: hi_q <= mem_rdata;
			S_FL: op_q <= {hi_q, mem_rdata};
			S_RY: vx_q <= rf_out;
			S_EX: begin
				alu_q  <= alu_res;
				coll_q <= 1'b0;
				xs_q   <= vx_q[COL_W-1:0];
				ys_q   <= vy[ROW_W-1:0];
				bcd_q  <= bcd_now;
				cnt_q  <= (op_q[15:12] == OP_MISC && op_kk == F_BCD) ? 4'd1 : 4'd0;
				case (op_q[15:12])
					OP_SER, OP_SNER: unk_q <= (op_n != 4'd0);
					OP_ALU: unk_q <= !(op_n == ALU_MOV || op_n == ALU_OR ||
					                   op_n == ALU_AND || op_n == ALU_XOR ||
					                   op_n == ALU_ADD || op_n == ALU_SUB ||
					                   op_n == ALU_SHR || op_n == ALU_SBN ||
					                   op_n == ALU_SHL);
					OP_KEY: unk_q <= !(op_kk == K_SKP || op_kk == K_SKNP);
					OP_MISC: unk_q <= !(op_kk == F_GDT || op_kk == F_WK ||
					                    op_kk == F_SDT || op_kk == F_SST ||
					                    op_kk == F_ADI || op_kk == F_FNT ||
					                    op_kk == F_BCD || op_kk == F_SAV ||
					                    op_kk == F_LOD);
					default: ;
				endcase
			end
			S_DWR: begin
				if ((scr_out & pattern) != 64'd0) coll_q <= 1'b1;
				cnt_q <= cnt_q + 4'd1;
			end
			S_BCD, S_SVWR, S_LDWR: cnt_q <= cnt_q + 4'd1;
			S_SRD: row_q <= scr_out;
			S_FIN: beep_q <= (snd_q == 8'd1);
			default: ;
		endcase
	end

	// outputs
	always_comb begin
		busy            = (state_q != S_IDLE);
		done            = (state_q == S_RESP);
		program_counter = pc_q;
		executed_opcode = (kind_q == KIND_EXEC) ? op_q : 16'd0;
		flag_value      = vf_q;
		beep            = beep_q;
		unknown_opcode  = unk_q;
		screen_row      = row_q;
	end
endmodule
`default_nettype wire
